### rtl/square_wave_sound_channel_defines.svh
// Assertion helpers for the square channel RTL.
`ifndef SQUARE_WAVE_SOUND_CHANNEL_DEFINES_SVH
`define SQUARE_WAVE_SOUND_CHANNEL_DEFINES_SVH

// Same-cycle implication on i_clk, disabled during reset.
`define SQWV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on i_clk, disabled during reset.
`define SQWV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sqwv_pkg.sv
package sqwv_pkg;

    typedef enum logic [1:0] {
        CMD_CLOCK  = 2'd0,
        CMD_LENGTH = 2'd1,
        CMD_ENV    = 2'd2,
        CMD_WRITE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_DUTY    = 2'd0,
        REG_ENV     = 2'd1,
        REG_FREQ_LO = 2'd2,
        REG_CTRL    = 2'd3
    } t_reg_sel;

    typedef struct packed {
        t_cmd       cmd;
        t_reg_sel   sel;
        logic [7:0] data;
    } t_item;

    localparam int unsigned REG_COUNT      = 4;
    localparam int unsigned BIT_LEN_ENABLE = 6;
    localparam int unsigned BIT_ENV_UP     = 3;

    localparam logic [13:0] TIMER_RESET = 14'd1;
    localparam logic [6:0]  LENGTH_FULL = 7'd64;
    localparam logic [11:0] FREQ_BASE   = 12'd2048;
    localparam logic [3:0]  VOLUME_MAX  = 4'd15;

    // Bit n of a pattern plays at phase n.
    localparam logic [7:0] DUTY_PATTERN [4] = '{8'h01, 8'h81, 8'h87, 8'h7E};

    // Envelope period; zero counts as eight.
    function automatic logic [3:0] period_load(input logic [7:0] v);
        return (v[2:0] == 3'd0) ? 4'd8 : {1'b0, v[2:0]};
    endfunction

endpackage

### rtl/sqwv_core.sv
module sqwv_core
    import sqwv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_item       i_item,
    output logic [7:0]  o_sample,
    output logic        o_channel_on
);

    logic [7:0]  r_regs [REG_COUNT];
    logic [7:0]  n_regs [REG_COUNT];
    logic [13:0] r_freq_timer, n_freq_timer;
    logic [2:0]  r_phase, n_phase;
    logic [6:0]  r_len, n_len;
    logic [3:0]  r_env_count, n_env_count;
    logic [3:0]  r_vol, n_vol;
    logic        r_env_active, n_env_active;
    logic        r_chan_en, n_chan_en;
    logic [7:0]  r_sample, n_sample;

    logic [13:0] w_timer_dec;
    logic [10:0] w_freq;
    logic [11:0] w_reload;
    logic [6:0]  w_len_dec;
    logic [3:0]  w_env_dec;
    logic [7:0]  w_pattern;

    assign w_timer_dec = r_freq_timer - 14'd1;
    assign w_freq      = {r_regs[REG_CTRL][2:0], r_regs[REG_FREQ_LO]};
    assign w_reload    = FREQ_BASE - {1'b0, w_freq};
    assign w_len_dec   = r_len - 7'd1;
    assign w_env_dec   = r_env_count - 4'd1;
    assign w_pattern   = DUTY_PATTERN[r_regs[REG_DUTY][7:6]];

    always_comb begin
        n_regs       = r_regs;
        n_freq_timer = r_freq_timer;
        n_phase      = r_phase;
        n_len        = r_len;
        n_env_count  = r_env_count;
        n_vol        = r_vol;
        n_env_active = r_env_active;
        n_chan_en    = r_chan_en;
        n_sample     = r_sample;
        unique case (i_item.cmd)
            CMD_CLOCK: begin
                n_freq_timer = w_timer_dec;
                if (w_timer_dec == 14'd0) begin
                    n_freq_timer = {w_reload, 2'b00};
                    n_phase      = r_phase + 3'd1;
                end
                // volume * 17 is the volume nibble repeated
                n_sample = w_pattern[n_phase] ? {r_vol, r_vol} : 8'd0;
            end
            CMD_LENGTH: begin
                if (r_len != 7'd0 && r_regs[REG_CTRL][BIT_LEN_ENABLE]) begin
                    n_len = w_len_dec;
                    if (w_len_dec == 7'd0) begin
                        n_chan_en = 1'b0;
                    end
                end
            end
            CMD_ENV: begin
                if (r_env_active) begin
                    n_env_count = w_env_dec;
                    if (w_env_dec == 4'd0) begin
                        n_env_count = period_load(r_regs[REG_ENV]);
                        if (r_regs[REG_ENV][2:0] != 3'd0) begin
                            // stop at the edge instead of wrapping
                            if (r_regs[REG_ENV][BIT_ENV_UP]) begin
                                if (r_vol == VOLUME_MAX) begin
                                    n_env_active = 1'b0;
                                end else begin
                                    n_vol = r_vol + 4'd1;
                                end
                            end else begin
                                if (r_vol == 4'd0) begin
                                    n_env_active = 1'b0;
                                end else begin
                                    n_vol = r_vol - 4'd1;
                                end
                            end
                        end
                    end
                end
            end
            CMD_WRITE: begin
                n_regs[i_item.sel] = i_item.data;
                unique case (i_item.sel)
                    REG_DUTY: begin
                        n_len = LENGTH_FULL - {1'b0, i_item.data[5:0]};
                    end
                    REG_ENV: begin
                        if (i_item.data[7:3] == 5'd0) begin
                            n_chan_en = 1'b0;
                        end
                        n_env_count = period_load(i_item.data);
                        n_vol       = i_item.data[7:4];
                    end
                    REG_FREQ_LO: begin
                    end
                    REG_CTRL: begin
                        if (i_item.data[BIT_LEN_ENABLE]) begin
                            n_env_active = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) begin
                r_regs[i] <= 8'd0;
            end
            r_freq_timer <= TIMER_RESET;
            r_phase      <= 3'd0;
            r_len        <= 7'd0;
            r_env_count  <= 4'd0;
            r_vol        <= 4'd0;
            r_env_active <= 1'b0;
            r_chan_en    <= 1'b1;
            r_sample     <= 8'd0;
        end else if (i_step) begin
            r_regs       <= n_regs;
            r_freq_timer <= n_freq_timer;
            r_phase      <= n_phase;
            r_len        <= n_len;
            r_env_count  <= n_env_count;
            r_vol        <= n_vol;
            r_env_active <= n_env_active;
            r_chan_en    <= n_chan_en;
            r_sample     <= n_sample;
        end
    end

    assign o_sample     = n_sample;
    assign o_channel_on = n_chan_en;

endmodule

### rtl/square_wave_sound_channel.sv
// Datapath: an item is taken into the input register, then passes into the result register.
// Throughput: one item per cycle while the output is not stalled; the channel state updates in a single pass.
// Input stalls only while the input register is full and a result is held in the output register under output stall.
// Reset (synchronous, active low): registers 0, timer 1, channel enabled, no valid data.
`include "square_wave_sound_channel_defines.svh"

module square_wave_sound_channel
    import sqwv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_command,
    input  logic [1:0] i_reg_select,
    input  logic [7:0] i_write_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_sample,
    output logic       o_channel_on
);

    logic       r_in_valid;
    t_item      r_in_item;
    logic       r_out_valid;
    logic [7:0] r_out_sample;
    logic       r_out_channel_on;

    logic       w_advance;
    logic       w_in_xfer;
    logic [7:0] w_sample;
    logic       w_channel_on;

    assign w_advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && r_out_valid && i_stall;
    assign w_in_xfer = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_item.cmd  <= t_cmd'(i_command);
            r_in_item.sel  <= t_reg_sel'(i_reg_select);
            r_in_item.data <= i_write_data;
        end
    end

    sqwv_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_item       (r_in_item),
        .o_sample     (w_sample),
        .o_channel_on (w_channel_on)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_sample     <= w_sample;
            r_out_channel_on <= w_channel_on;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sample     = r_out_sample;
    assign o_channel_on = r_out_channel_on;

    `SQWV_ASSERT_NOW(a_stall_only_when_blocked, o_stall, o_valid && i_stall, "stray stall")
    `SQWV_ASSERT_NOW(a_sample_times_17, o_valid, o_sample[7:4] == o_sample[3:0], "bad sample")
    `SQWV_ASSERT_NEXT(a_channel_stays_off, o_valid && !o_channel_on, !o_channel_on, "back on")

endmodule
